// ===== rtl/gswd_pkg.sv =====
`timescale 1ns / 1ps
package gswd_pkg;

   // Width of the recovered plaintext word
   localparam int PT_W = 30;

   // Configuration register index width and register codes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_MODULUS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MODE    = 1'b1;

   // Reset values of the configuration registers
   localparam logic [30:0] MODULUS_RESET = 31'd65521;
   localparam logic        MODE_RESET    = 1'b1;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED_PROD,
      ST_ACC,
      ST_RED_SUB,
      ST_DECIDE,
      ST_EMIT
   } eng_state_type;

endpackage

// ===== rtl/gswd_queue.sv =====
`timescale 1ns / 1ps
module gswd_queue #(
   parameter int W     = 63,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_valid,
   output logic         wr_ready,
   input  logic [W-1:0] wr_data,
   output logic         rd_valid,
   input  logic         rd_ready,
   output logic [W-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming transaction
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/gswd_engine.sv =====
`timescale 1ns / 1ps
module gswd_engine #(
   parameter int COEFF_BITS = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [gswd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [30:0]                   csr_wdata,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [COEFF_BITS-1:0]         in_cipher,
   input  logic [COEFF_BITS-1:0]         in_key,
   input  logic                          in_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gswd_pkg::PT_W-1:0]     rsp_plaintext
);

   localparam int CB    = COEFF_BITS;
   localparam int WIDE  = 2 * CB;
   localparam int CNT_W = $clog2(WIDE + 1);
   localparam int IDX_W = $clog2(CB + 1);
   localparam int PT_W  = gswd_pkg::PT_W;
   localparam int EXT_W = WIDE + PT_W;
   localparam logic [CB-1:0] MinQ = CB'(4);

   gswd_pkg::eng_state_type state_ff, state_in;

   logic [CB-1:0]    modulus_ff, modulus_in;
   logic             multi_ff, multi_in;
   logic [CB-1:0]    a_ff, a_in, b_ff, b_in;
   logic             last_ff, last_in;
   logic [WIDE-1:0]  shift_ff, shift_in;
   logic [CB-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CB-1:0]    row_sum_ff, row_sum_in;
   logic [CB-1:0]    x_ff, x_in;
   logic [PT_W-1:0]  bits_ff, bits_in;
   logic [IDX_W-1:0] rows_left_ff, rows_left_in;
   logic             start_ff, start_in;
   logic [PT_W-1:0]  result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PT_W-1:0]  rsp_pt_ff, rsp_pt_in;

   logic [CB-1:0]    q;
   logic [IDX_W-1:0] blen, top, row_idx;
   logic [CB:0]      red_cand, acc_sum, single_t, xr_wide;
   logic [CB-1:0]    red_next, acc_red, xr, q_minus_xr, half, near0, mid_gap;
   logic [EXT_W-1:0] sub_ext;
   logic             new_bit, single_bit, out_free;

   // Clamp the modulus and find its bit length
   always_comb begin
      q    = (modulus_ff < MinQ) ? MinQ : modulus_ff;
      blen = '0;
      for (int k = 0; k < CB; k++) begin
         if (q[k]) begin
            blen = IDX_W'(k + 1);
         end
      end
      top     = blen - IDX_W'(2);
      row_idx = start_ff ? top : ((rows_left_ff > top) ? top : rows_left_ff);
   end

   // One step of the bit-serial reduction, plus the row accumulate
   always_comb begin
      red_cand = {rem_ff, shift_ff[WIDE-1]};
      red_next = (red_cand >= {1'b0, q}) ? CB'(red_cand - {1'b0, q}) : red_cand[CB-1:0];
      acc_sum  = {1'b0, row_sum_ff} + {1'b0, rem_ff};
      acc_red  = (acc_sum >= {1'b0, q}) ? CB'(acc_sum - {1'b0, q}) : acc_sum[CB-1:0];
      sub_ext  = {{WIDE{1'b0}}, bits_ff} << row_idx;
   end

   // Bit decisions at the end of a row
   always_comb begin
      single_t   = {1'b0, x_ff} + ((CB + 1)'(1) << (top - IDX_W'(1)));
      single_bit = single_t[top];
      xr_wide    = (x_ff >= rem_ff) ? {1'b0, x_ff} - {1'b0, rem_ff}
                                    : {1'b0, x_ff} + {1'b0, q} - {1'b0, rem_ff};
      xr         = xr_wide[CB-1:0];
      q_minus_xr = q - xr;
      half       = q >> 1;
      near0      = (xr < q_minus_xr) ? xr : q_minus_xr;
      mid_gap    = (xr >= half) ? xr - half : half - xr;
      new_bit    = (near0 >= mid_gap);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gswd_pkg::ST_IDLE:     if (in_valid) state_in = gswd_pkg::ST_MUL;
         gswd_pkg::ST_MUL:      state_in = gswd_pkg::ST_RED_PROD;
         gswd_pkg::ST_RED_PROD: if (cnt_ff == CNT_W'(1)) state_in = gswd_pkg::ST_ACC;
         gswd_pkg::ST_ACC: begin
            if (!last_ff) begin
               state_in = gswd_pkg::ST_IDLE;
            end else if (multi_ff) begin
               state_in = gswd_pkg::ST_RED_SUB;
            end else begin
               state_in = gswd_pkg::ST_DECIDE;
            end
         end
         gswd_pkg::ST_RED_SUB:  if (cnt_ff == CNT_W'(1)) state_in = gswd_pkg::ST_DECIDE;
         gswd_pkg::ST_DECIDE: begin
            if (!multi_ff || row_idx == '0) begin
               state_in = gswd_pkg::ST_EMIT;
            end else begin
               state_in = gswd_pkg::ST_IDLE;
            end
         end
         gswd_pkg::ST_EMIT:     if (out_free) state_in = gswd_pkg::ST_IDLE;
         default:               state_in = gswd_pkg::ST_IDLE;
      endcase
   end

   // Datapath and control outputs
   always_comb begin
      in_ready     = (state_ff == gswd_pkg::ST_IDLE);
      modulus_in   = modulus_ff;
      multi_in     = multi_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      row_sum_in   = row_sum_ff;
      x_in         = x_ff;
      bits_in      = bits_ff;
      rows_left_in = rows_left_ff;
      start_in     = start_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pt_in    = rsp_pt_ff;
      case (state_ff)
         gswd_pkg::ST_IDLE: begin
            a_in    = in_cipher;
            b_in    = in_key;
            last_in = in_last;
         end
         gswd_pkg::ST_MUL: begin
            shift_in = WIDE'(a_ff) * WIDE'(b_ff);
            rem_in   = '0;
            cnt_in   = CNT_W'(WIDE);
         end
         gswd_pkg::ST_RED_PROD, gswd_pkg::ST_RED_SUB: begin
            rem_in   = red_next;
            shift_in = shift_ff << 1;
            cnt_in   = cnt_ff - CNT_W'(1);
         end
         gswd_pkg::ST_ACC: begin
            if (last_ff) begin
               row_sum_in = '0;
               x_in       = acc_red;
               shift_in   = sub_ext[WIDE-1:0];
               rem_in     = '0;
               cnt_in     = CNT_W'(WIDE);
            end else begin
               row_sum_in = acc_red;
            end
         end
         gswd_pkg::ST_DECIDE: begin
            if (!multi_ff) begin
               result_in = PT_W'(single_bit);
            end else if (row_idx == '0) begin
               result_in = bits_ff | (PT_W'(new_bit) << (top - row_idx));
               bits_in   = '0;
               start_in  = 1'b1;
            end else begin
               bits_in      = bits_ff | (PT_W'(new_bit) << (top - row_idx));
               rows_left_in = row_idx - IDX_W'(1);
               start_in     = 1'b0;
            end
         end
         gswd_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pt_in    = result_ff;
            end
         end
         default: begin
         end
      endcase
      // Register writes restart any decryption in progress
      if (csr_we) begin
         if (csr_index == gswd_pkg::REG_MODULUS) begin
            modulus_in = csr_wdata[CB-1:0];
         end else begin
            multi_in = csr_wdata[0];
         end
         row_sum_in = '0;
         bits_in    = '0;
         start_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gswd_pkg::ST_IDLE;
         modulus_ff   <= gswd_pkg::MODULUS_RESET[CB-1:0];
         multi_ff     <= gswd_pkg::MODE_RESET;
         row_sum_ff   <= '0;
         bits_ff      <= '0;
         rows_left_ff <= '0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         multi_ff     <= multi_in;
         row_sum_ff   <= row_sum_in;
         bits_ff      <= bits_in;
         rows_left_ff <= rows_left_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      last_ff   <= last_in;
      shift_ff  <= shift_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      x_ff      <= x_in;
      result_ff <= result_in;
      rsp_pt_ff <= rsp_pt_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_plaintext = rsp_pt_ff;

endmodule

// ===== rtl/gsw_lattice_decrypt_core.sv =====
`timescale 1ns / 1ps
// GSW decryption core: ciphertext and key entries enter through a two-deep
// queue and are worked off by a back-end sequencer. Each entry is multiplied
// and the product reduced modulo q by the bit-serial reduction, one bit a
// cycle; the last entry of a row then takes a decide step in single-bit mode,
// and in multi-bit mode first a second reduction pass, where the same
// reduction unit reduces the shifted recovered bits, and a row that yields a
// result then loads the output register. A finished result waits in that
// register while the next transactions queue. A register write restarts the
// decryption.
module gsw_lattice_decrypt_core #(
   parameter int COEFF_BITS = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [COEFF_BITS-1:0]          req_cipher_elem,
   input  logic [COEFF_BITS-1:0]          req_key_elem,
   input  logic                           req_last_of_row,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gswd_pkg::PT_W-1:0]      rsp_plaintext,
   input  logic                           csr_we,
   input  logic [gswd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [30:0]                    csr_wdata
);

   localparam int QW = 2 * COEFF_BITS + 1;

   logic          q_valid, q_ready;
   logic [QW-1:0] q_data;

   // Front: buffer incoming transactions
   gswd_queue #(.W(QW), .DEPTH(2)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_data  ({req_last_of_row, req_key_elem, req_cipher_elem}),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   // Back: modular accumulate and bit recovery
   gswd_engine #(.COEFF_BITS(COEFF_BITS)) u_engine (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_cipher     (q_data[COEFF_BITS-1:0]),
      .in_key        (q_data[2*COEFF_BITS-1:COEFF_BITS]),
      .in_last       (q_data[2*COEFF_BITS]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_plaintext (rsp_plaintext)
   );

endmodule

// ===== rtl/gswd_checker.sv =====
`timescale 1ns / 1ps
module gswd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [gswd_pkg::PT_W-1:0]      rsp_plaintext,
   input logic                           csr_we,
   input logic [gswd_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [30:0]                    csr_wdata
);

   logic mode_ff;

   // Track the decrypt mode from register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= gswd_pkg::MODE_RESET;
      end else if (csr_we && csr_index == gswd_pkg::REG_MODE) begin
         mode_ff <= csr_wdata[0];
      end
   end

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_plaintext))
      else $error("response changed while stalled");

   // Single-bit mode yields one bit only
   a_single_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !mode_ff |-> rsp_plaintext[gswd_pkg::PT_W-1:1] == '0)
      else $error("single-bit result wider than one bit");

   // No response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind gsw_lattice_decrypt_core gswd_checker u_checker (.*);
